FILE: src/ovd_pkg.sv
// Package with the result type and length tables of the offset varint decoder.
`default_nettype none
package ovd_pkg;

    localparam int unsigned GROUP_BITS = 7;
    localparam int unsigned MAX_BYTES  = 5;
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned COUNT_W    = 3;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [COUNT_W-1:0] t_count;

    typedef struct packed {
        t_value value;
        t_count byte_count;
        logic   overlong_error;
    } t_result;

    function automatic t_value len_offset(input t_count idx);
        t_value r;
        case (idx)
            3'd0:    r = 32'h0000_0000;
            3'd1:    r = 32'h0000_0080;
            3'd2:    r = 32'h0000_4080;
            3'd3:    r = 32'h0020_4080;
            3'd4:    r = 32'h1020_4080;
            default: r = 32'h0000_0000;
        endcase
        return r;
    endfunction

    function automatic t_value sign_limit(input t_count idx);
        t_value r;
        case (idx)
            3'd0:    r = 32'h0000_0040;
            3'd1:    r = 32'h0000_2000;
            3'd2:    r = 32'h0010_0000;
            3'd3:    r = 32'h0800_0000;
            default: r = 32'hFFFF_FFFF;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: src/offset_varint_decoder_top.sv
// Top level of the offset and sign-extended base-128 varint decoder.
// A result enters the output register when its terminating word is accepted, or the skid entry if output is stalled.
// Throughput: one word per cycle while o_stall is low; the decode is a single pass over the current word.
// A two-entry output register with skid; input acceptance stops only while the skid entry is full (o_stall).
// Synchronous active-low reset clears the accumulator, byte index, mode and output valids.
`default_nettype none
module offset_varint_decoder_top (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic                  i_cfg_wr_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [7:0]            i_in_byte,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output ovd_pkg::t_value            o_value,
    output ovd_pkg::t_count            o_byte_count,
    output logic                       o_overlong_error
);
    import ovd_pkg::*;

    logic    r_signed_mode;
    t_value  r_acc,  n_acc;
    t_count  r_idx,  n_idx;
    t_result r_out,  r_skid, n_res;
    logic    r_out_valid, r_skid_valid;
    logic    accept, res_fire, out_free;
    t_value  shifted;
    t_value  merged, dec;

    assign o_stall = r_skid_valid;
    assign accept  = i_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        case (r_idx)
            3'd0:    shifted = {{(VALUE_W-7){1'b0}}, i_in_byte[6:0]};
            3'd1:    shifted = {{(VALUE_W-14){1'b0}}, i_in_byte[6:0], 7'd0};
            3'd2:    shifted = {{(VALUE_W-21){1'b0}}, i_in_byte[6:0], 14'd0};
            3'd3:    shifted = {{(VALUE_W-28){1'b0}}, i_in_byte[6:0], 21'd0};
            3'd4:    shifted = {i_in_byte[3:0], 28'd0};
            default: shifted = '0;
        endcase
        merged = r_acc | shifted;

        if (r_signed_mode) begin
            if (r_idx < 3'd4 && merged >= sign_limit(r_idx)) begin
                dec = merged - (sign_limit(r_idx) << 1);
            end else begin
                dec = merged;
            end
        end else begin
            dec = merged + len_offset(r_idx);
        end

        n_acc    = merged;
        n_idx    = r_idx + 3'd1;
        res_fire = 1'b0;
        n_res.value          = dec;
        n_res.byte_count     = r_idx + 3'd1;
        n_res.overlong_error = 1'b0;
        if (i_in_byte[7]) begin
            if (r_idx == 3'(MAX_BYTES - 1)) begin
                res_fire = 1'b1;
                n_res.value          = '0;
                n_res.byte_count     = 3'(MAX_BYTES);
                n_res.overlong_error = 1'b1;
                n_acc = '0;
                n_idx = '0;
            end
        end else begin
            res_fire = 1'b1;
            n_acc = '0;
            n_idx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b0;
            r_acc         <= '0;
            r_idx         <= '0;
            r_out_valid   <= 1'b0;
            r_skid_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_signed_mode <= i_cfg_wr_data;
            end
            if (accept) begin
                r_acc <= n_acc;
                r_idx <= n_idx;
            end
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out       <= n_res;
                    r_out_valid <= accept && res_fire;
                end
            end else if (accept && res_fire) begin
                r_skid       <= n_res;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_value          = r_out.value;
    assign o_byte_count     = r_out.byte_count;
    assign o_overlong_error = r_out.overlong_error;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("Skid entry held while output register is empty.");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx < 3'(MAX_BYTES))
        else $error("Byte index out of range.");

    a_overlong_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.overlong_error) |->
            (r_out.value == '0 && r_out.byte_count == 3'(MAX_BYTES)))
        else $error("Overlong result carries wrong fields.");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && res_fire) |=> (r_idx == '0 && r_acc == '0))
        else $error("State not cleared after a terminating word.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.byte_count != 3'd0 && r_out.byte_count <= 3'(MAX_BYTES)))
        else $error("Result byte count out of range.");

endmodule
`default_nettype wire
